// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication that must hold in the following cycle.
`define ASC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/asc_pkg.sv =====
package asc_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_ENCODE = 2'd2;
  localparam logic [1:0] FUNC_DECODE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADSHIFT = 2'd3;

  localparam logic signed [6:0] SHIFT_RESET = 7'sd1;

  typedef struct packed {
    logic       is_clear;
    logic       is_add;
    logic       is_decode;
    logic [7:0] symbol;
  } item_t;

endpackage

// ===== rtl/asc_ram.sv =====
module asc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/asc_front.sv =====
module asc_front
  import asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] symbol,
  output logic       q_valid,
  output item_t      q_head,
  input  logic       q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  item_t          q_item [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [FW-1:0]  fill;
  item_t          cls;
  logic           push;
  logic           pop;

  always_comb begin
    cls.is_clear  = (func == FUNC_CLEAR);
    cls.is_add    = (func == FUNC_ADD);
    cls.is_decode = (func == FUNC_DECODE);
    cls.symbol    = symbol;
  end

  assign in_ready = (fill != FW'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_head   = q_item[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_item[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/asc_back.sv =====
module asc_back
  import asc_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       q_valid,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       in_alphabet,
  output logic [1:0] status,
  output logic [6:0] symbol_count
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int SW = CW + 8;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_FETCH   = 3'd3;
  localparam logic [2:0] S_WAIT    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]             state;
  logic signed [6:0]      shift;
  logic [CW-1:0]          count;
  logic [CW-1:0]          n;
  logic [CW-1:0]          idx;
  logic                   rvalid;
  logic [AW-1:0]          raddr_d;
  logic [AW-1:0]          pos;
  logic                   found;
  item_t                  cur;
  logic signed [SW-1:0]   ksum;
  logic [7:0]             res_sym;
  logic [1:0]             res_status;

  logic                   issue;
  logic                   hit;
  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [7:0]             ram_rdata;
  logic [6:0]             mag;
  logic                   bad_shift;
  logic signed [SW-1:0]   pos_s;
  logic signed [SW-1:0]   shift_s;
  logic signed [SW-1:0]   n_s;
  logic signed [SW-1:0]   sum;
  logic signed [SW-1:0]   k_fix;
  logic [CW+6:0]          count_wide;

  assign issue   = (state == S_SEARCH) && (idx < n);
  assign hit     = (state == S_SEARCH) && rvalid && (ram_rdata == cur.symbol);
  assign mag     = shift[6] ? 7'(-shift) : shift;
  assign bad_shift = (shift == 7'sd0) || ({{CW{1'b0}}, mag} >= {7'd0, n});
  assign pos_s   = signed'({{(SW - AW){1'b0}}, pos});
  assign shift_s = signed'({{(SW - 7){shift[6]}}, shift});
  assign n_s     = signed'({{(SW - CW){1'b0}}, n});
  assign sum     = cur.is_decode ? pos_s - shift_s : pos_s + shift_s;
  assign k_fix   = (ksum >= n_s) ? ksum - n_s : ((ksum < 0) ? ksum + n_s : ksum);
  assign ram_raddr = (state == S_FETCH) ? k_fix[AW-1:0] : idx[AW-1:0];
  assign ram_we  = (state == S_RESOLVE) && cur.is_add && !found &&
                   (n < CW'(TABLE_SIZE));
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign count_wide = {7'd0, count};

  asc_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n[AW-1:0]),
    .wdata (cur.symbol),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= SHIFT_RESET;
    end else if (cfg_write) begin
      shift <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rvalid <= 1'b0;
          if (q_valid) begin
            if (q_head.is_clear) begin
              count <= '0;
              state <= S_DONE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          rvalid <= issue;
          if (hit || (!issue && !rvalid)) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          rvalid <= 1'b0;
          if (ram_we) begin
            count <= n + 1'b1;
          end
          if (!cur.is_add && !bad_shift && found) begin
            state <= S_FETCH;
          end else begin
            state <= S_DONE;
          end
        end
        S_FETCH: state <= S_WAIT;
        S_WAIT:  state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur        <= q_head;
        n          <= count;
        idx        <= '0;
        found      <= 1'b0;
        res_sym    <= q_head.symbol;
        res_status <= ST_OK;
      end
      S_SEARCH: begin
        raddr_d <= idx[AW-1:0];
        if (issue) begin
          idx <= idx + 1'b1;
        end
        if (hit) begin
          found <= 1'b1;
          pos   <= raddr_d;
        end
      end
      S_RESOLVE: begin
        ksum <= sum;
        if (cur.is_add) begin
          if (found) begin
            res_status <= ST_DUP;
          end else if (n >= CW'(TABLE_SIZE)) begin
            res_status <= ST_FULL;
          end
        end else if (bad_shift) begin
          res_status <= ST_BADSHIFT;
        end
      end
      S_WAIT: res_sym <= ram_rdata;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_symbol   <= res_sym;
          in_alphabet  <= found;
          status       <= res_status;
          symbol_count <= count_wide[6:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/alphabet_shift_cipher.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_ready     func, symbol
// out      out_valid / out_ready   out_symbol, in_alphabet, status, symbol_count
// cfg      cfg_write               cfg_data (signed shift)
//
// An add, encode or decode keeps the back end busy while its search reads the symbols in
// the table one entry per cycle through the single RAM read port; an encode or decode that
// finds its byte under a valid shift then also passes S_FETCH and S_WAIT for the read of
// the shifted entry, and a clear goes straight to the output.
// A two-entry queue keeps accepting items while the back end searches, until it is full.
// Reset is synchronous and active high; it empties the table and sets the shift to 1.
// A stalled output holds its transaction and stops the back end; the queue fills meanwhile.
module alphabet_shift_cipher
  import asc_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       in_alphabet,
  output logic [1:0] status,
  output logic [6:0] symbol_count
);

  logic  q_valid;
  item_t q_head;
  logic  q_pop;

  asc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .symbol   (symbol),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  asc_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_symbol   (out_symbol),
    .in_alphabet  (in_alphabet),
    .status       (status),
    .symbol_count (symbol_count)
  );

endmodule

// ===== rtl/asc_checker.sv =====
`include "assert_macros.svh"

module asc_checker
  import asc_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic       in_alphabet,
  input logic [1:0] status,
  input logic [6:0] symbol_count
);

  localparam logic [6:0] FULL_COUNT = 7'(TABLE_SIZE);

  `ASC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_symbol), "stalled output transaction changed")
  `ASC_ASSERT_SAME(a_dup_found, clk, rst, out_valid && (status == ST_DUP), in_alphabet, "duplicate reported for a symbol not in the table")
  `ASC_ASSERT_SAME(a_full_count, clk, rst, out_valid && (status == ST_FULL), symbol_count == FULL_COUNT, "table full reported below capacity")
  `ASC_ASSERT_SAME(a_pass_through, clk, rst, out_valid && !in_alphabet && (status == ST_OK), symbol_count <= FULL_COUNT, "symbol count exceeds capacity")

endmodule

bind alphabet_shift_cipher asc_checker #(
  .TABLE_SIZE (TABLE_SIZE)
) u_asc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_symbol   (out_symbol),
  .in_alphabet  (in_alphabet),
  .status       (status),
  .symbol_count (symbol_count)
);

// ===== tb/alphabet_shift_cipher_test.sv =====
module alphabet_shift_cipher_test;
  import asc_pkg::*;

  localparam int TABLE_DEPTH = TABLE_SIZE_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       in_alphabet;
    logic [1:0] status;
    logic [6:0] symbol_count;
  } cipher_result_t;

  class cipher_scoreboard;
    logic [7:0] alphabet[TABLE_DEPTH];
    int unsigned held_count;
    logic signed [6:0] shift;
    cipher_result_t awaited[$];
    int unsigned errors;

    function new();
      held_count = 0;
      shift = SHIFT_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_shift(logic signed [6:0] value);
      shift = value;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] sym);
      cipher_result_t r;
      int idx;
      int n;
      int mag;
      int k;
      r.out_symbol = sym;
      r.in_alphabet = 1'b0;
      r.status = ST_OK;
      idx = -1;
      for (int i = 0; i < held_count; i++) begin
        if (idx < 0 && alphabet[i] == sym) idx = i;
      end
      case (op)
        FUNC_CLEAR: begin
          held_count = 0;
        end
        FUNC_ADD: begin
          if (idx >= 0) begin
            r.in_alphabet = 1'b1;
            r.status = ST_DUP;
          end else if (held_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            alphabet[held_count] = sym;
            held_count++;
          end
        end
        default: begin
          n = held_count;
          mag = int'(shift);
          if (mag < 0) mag = -mag;
          r.in_alphabet = (idx >= 0);
          if (shift == 0 || mag >= n) begin
            r.status = ST_BADSHIFT;
          end else if (idx >= 0) begin
            k = (op == FUNC_ENCODE) ? idx + int'(shift) : idx - int'(shift);
            if (k >= n) k -= n;
            if (k < 0) k += n;
            r.out_symbol = alphabet[k];
          end
        end
      endcase
      r.symbol_count = held_count[6:0];
      awaited.push_back(r);
    endfunction

    task check_result(cipher_result_t got);
      cipher_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %h arrived with no transaction pending", got));
      end else begin
        want = awaited.pop_front();
        if (got.out_symbol !== want.out_symbol)
          report($sformatf("out_symbol expected %h got %h", want.out_symbol, got.out_symbol));
        if (got.in_alphabet !== want.in_alphabet)
          report($sformatf("in_alphabet expected %b got %b", want.in_alphabet,
                           got.in_alphabet));
        if (got.status !== want.status)
          report($sformatf("status expected %0d got %0d", want.status, got.status));
        if (got.symbol_count !== want.symbol_count)
          report($sformatf("symbol_count expected %0d got %0d", want.symbol_count,
                           got.symbol_count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FUNC_CLEAR;
  logic [7:0] symbol = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_symbol;
  logic in_alphabet;
  logic [1:0] status;
  logic [6:0] symbol_count;

  cipher_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stuck_cycles = 0;
  int sent = 0;
  logic signed [6:0] cur_shift = SHIFT_RESET;

  alphabet_shift_cipher DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .symbol(symbol),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_symbol(out_symbol),
    .in_alphabet(in_alphabet),
    .status(status),
    .symbol_count(symbol_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : monitor
    cipher_result_t seen;
    if (!rst) begin
      if (cfg_write) sb.set_shift(cfg_data);
      if (out_valid && out_ready) begin
        seen = '{out_symbol, in_alphabet, status, symbol_count};
        sb.check_result(seen);
      end
      if (in_valid && in_ready) sb.note_input(func, symbol);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STALL_LIMIT);
    $display("FAIL alphabet_shift_cipher");
    $finish;
  end

  // All driving tasks start and end on a falling edge.
  task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = op;
    symbol = sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic write_shift(input logic signed [6:0] value);
    wait_drained();
    cfg_write = 1'b1;
    cfg_data = value;
    cur_shift = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 88; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 88; end
      default: begin send_idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // A well-formed sequence builds a fresh alphabet and then codes bytes with it;
  // the rest of the time a short burst of arbitrary transactions goes in.
  task automatic run_sequence();
    bit [255:0] used;
    logic [7:0] alphabet_syms[$];
    logic [7:0] s;
    int n;
    int mag;
    int pick;
    used = '0;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(10, 1))
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end else begin
      mag = (cur_shift < 0) ? -int'(cur_shift) : int'(cur_shift);
      pick = $urandom_range(9);
      if (pick < 2) n = TABLE_DEPTH;
      else if (pick < 5) n = $urandom_range(TABLE_DEPTH, (mag < 2) ? 2 : mag + 1);
      else n = $urandom_range(16, 2);
      send_item(FUNC_CLEAR, 8'($urandom_range(255)));
      while (alphabet_syms.size() < n) begin
        do s = 8'($urandom_range(255)); while (used[s]);
        used[s] = 1'b1;
        alphabet_syms.push_back(s);
        send_item(FUNC_ADD, s);
        if ($urandom_range(9) == 0)
          send_item(FUNC_ADD, alphabet_syms[$urandom_range(alphabet_syms.size() - 1)]);
      end
      if (n == TABLE_DEPTH) begin
        repeat ($urandom_range(2, 1)) begin
          do s = 8'($urandom_range(255)); while (used[s]);
          send_item(FUNC_ADD, s);
        end
        send_item(FUNC_ADD, alphabet_syms[$urandom_range(TABLE_DEPTH - 1)]);
      end
      repeat ($urandom_range(40, 8)) begin
        if ($urandom_range(99) < 85) s = alphabet_syms[$urandom_range(alphabet_syms.size() - 1)];
        else s = 8'($urandom_range(255));
        send_item($urandom_range(1) ? FUNC_ENCODE : FUNC_DECODE, s);
      end
    end
    if ($urandom_range(9) == 0) wait_drained();
  endtask

  initial begin : stimulus
    int shift_plan[8];
    int target;
    shift_plan = '{63, -63, 1, -1, 0, 2, -2, 17};
    shift_plan[5] = int'($urandom_range(126)) - 63;
    shift_plan[7] = int'($urandom_range(126)) - 63;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_idling(3);
    send_item(FUNC_ENCODE, 8'h00);
    send_item(FUNC_DECODE, 8'hFF);
    send_item(FUNC_ADD, 8'h00);
    send_item(FUNC_ADD, 8'hFF);
    send_item(FUNC_ADD, 8'h55);
    send_item(FUNC_ADD, 8'hAA);
    send_item(FUNC_ADD, 8'h00);
    send_item(FUNC_ENCODE, 8'h00);
    send_item(FUNC_ENCODE, 8'hAA);
    send_item(FUNC_DECODE, 8'h00);
    send_item(FUNC_DECODE, 8'h55);
    send_item(FUNC_ENCODE, 8'h12);
    write_shift(7'sd4);
    send_item(FUNC_ENCODE, 8'h55);
    send_item(FUNC_DECODE, 8'h12);
    write_shift(7'sd0);
    send_item(FUNC_ENCODE, 8'hFF);
    write_shift(-7'sd3);
    send_item(FUNC_ENCODE, 8'h00);
    send_item(FUNC_DECODE, 8'h00);
    write_shift(-7'sd4);
    send_item(FUNC_DECODE, 8'hAA);
    send_item(FUNC_CLEAR, 8'hA5);
    send_item(FUNC_ENCODE, 8'hA5);
    send_item(FUNC_ADD, 8'h80);
    send_item(FUNC_DECODE, 8'h80);

    for (int p = 0; p < 8; p++) begin
      write_shift(7'(shift_plan[p]));
      set_idling(p % 4);
      target = sent + 180;
      while (sent < target) run_sequence();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.errors == 0) begin
      $display("PASS alphabet_shift_cipher");
    end else begin
      $display("FAIL alphabet_shift_cipher");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/asc_pkg.sv
rtl/asc_ram.sv
rtl/asc_front.sv
rtl/asc_back.sv
rtl/alphabet_shift_cipher.sv
rtl/asc_checker.sv
tb/alphabet_shift_cipher_test.sv
